// ----- hw/rtl/ilat_pkg.sv -----
// Shared constants, types and helper functions for the Ising lattice block.
// Used by all modules under hw/rtl but ilat_spin_ram; depends on nothing.
`timescale 1ns / 1ps

package ilat_pkg;

    // Lattice geometry
    localparam int ROWS      = 16;
    localparam int COLS      = 16;
    localparam int ROW_IDX_W = $clog2(ROWS);
    localparam int COL_IDX_W = $clog2(COLS);
    localparam int CNT_W     = $clog2(COLS + 1);
    localparam int LIM_W     = 9;

    // Port field widths
    localparam int OP_W     = 2;
    localparam int ROW_W    = 4;
    localparam int COL_W    = 4;
    localparam int RAND_W   = 32;
    localparam int DE_W     = 5;
    localparam int ENERGY_W = 11;
    localparam int MAGNET_W = 10;
    localparam int CFG_IDX_W = 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_FLIP   = 2'd1;
    localparam logic [OP_W-1:0] OP_RECOMP = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_EIGHT = 1'b1;

    typedef logic [COLS-1:0]              row_bits_t;
    typedef logic [ROW_IDX_W-1:0]         row_idx_t;
    typedef logic [COL_IDX_W-1:0]         col_idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic signed [DE_W-1:0]       de_t;
    typedef logic signed [ENERGY_W-1:0]   energy_t;
    typedef logic signed [MAGNET_W-1:0]   magnet_t;
    typedef logic [RAND_W-1:0]            rand_t;

    // Outcome of one flip attempt
    typedef struct packed {
        logic      accept;
        de_t       de;
        row_bits_t new_row;
    } flip_eval_t;

    // Contribution of one lattice row to the totals
    typedef struct packed {
        energy_t e_delta;
        magnet_t m_delta;
    } row_tally_t;

    function automatic cnt_t popcount(input row_bits_t bits);
        cnt_t cnt;
        cnt = '0;
        for (int i = 0; i < COLS; i++) begin
            cnt = cnt + CNT_W'(bits[i]);
        end
        return cnt;
    endfunction

    function automatic row_idx_t row_prev(input row_idx_t r);
        return (r == '0) ? ROW_IDX_W'(ROWS - 1) : r - row_idx_t'(1);
    endfunction

    function automatic row_idx_t row_next(input row_idx_t r);
        return (r == ROW_IDX_W'(ROWS - 1)) ? '0 : r + row_idx_t'(1);
    endfunction

    function automatic col_idx_t col_prev(input col_idx_t c);
        return (c == '0) ? COL_IDX_W'(COLS - 1) : c - col_idx_t'(1);
    endfunction

    function automatic col_idx_t col_next(input col_idx_t c);
        return (c == COL_IDX_W'(COLS - 1)) ? '0 : c + col_idx_t'(1);
    endfunction

endpackage

// ----- hw/rtl/ilat_spin_ram.sv -----
// Spin memory: one lattice row per entry, one write port, two registered read ports.
// Generic; depends on nothing.
`timescale 1ns / 1ps

module ilat_spin_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one row
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read two rows into registered outputs
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- hw/rtl/ilat_site_eval.sv -----
// Metropolis decision for one site from its row and the rows above and below.
// Depends on ilat_pkg.
`timescale 1ns / 1ps

module ilat_site_eval
    import ilat_pkg::*;
(
    input  row_bits_t  row_mid,
    input  row_bits_t  row_up,
    input  row_bits_t  row_down,
    input  col_idx_t   col_idx,
    input  rand_t      rand_val,
    input  rand_t      thr_four,
    input  rand_t      thr_eight,
    output flip_eval_t result
);

    logic       spin;
    logic [2:0] eq_cnt;
    col_idx_t   left_idx;
    col_idx_t   right_idx;

    // Count neighbors aligned with the site
    always_comb
    begin
        left_idx  = col_prev(col_idx);
        right_idx = col_next(col_idx);
        spin      = row_mid[col_idx];
        eq_cnt    = 3'(row_up[col_idx] == spin) + 3'(row_down[col_idx] == spin)
                  + 3'(row_mid[left_idx] == spin) + 3'(row_mid[right_idx] == spin);
    end

    // dE = 4 * aligned - 8; accept moves with dE <= 0, test uphill ones against thresholds
    always_comb
    begin
        result.de = $signed({eq_cnt, 2'b00} - 5'd8);
        priority if (eq_cnt <= 3'd2)
        begin
            result.accept = 1'b1;
        end
        else if (eq_cnt == 3'd3)
        begin
            result.accept = (rand_val <= thr_four);
        end
        else
        begin
            result.accept = (rand_val <= thr_eight);
        end
        result.new_row          = row_mid;
        result.new_row[col_idx] = ~spin;
    end

endmodule

// ----- hw/rtl/ilat_row_tally.sv -----
// Energy and magnetization contribution of one lattice row (right and down bonds).
// Depends on ilat_pkg.
`timescale 1ns / 1ps

module ilat_row_tally
    import ilat_pkg::*;
(
    input  row_bits_t  row_cur,
    input  row_bits_t  row_below,
    output row_tally_t tally
);

    row_bits_t           row_right;
    cnt_t                h_diff;
    cnt_t                v_diff;
    cnt_t                ones;
    logic [CNT_W:0]      diff_sum;

    // Unequal bonds cost +1, equal ones -1
    always_comb
    begin
        row_right     = {row_cur[0], row_cur[COLS-1:1]};
        h_diff        = popcount(row_cur ^ row_right);
        v_diff        = popcount(row_cur ^ row_below);
        ones          = popcount(row_cur);
        diff_sum      = {1'b0, h_diff} + {1'b0, v_diff};
        tally.e_delta = $signed(ENERGY_W'({diff_sum, 1'b0}) - ENERGY_W'(2 * COLS));
        tally.m_delta = $signed(MAGNET_W'({ones, 1'b0}) - MAGNET_W'(COLS));
    end

endmodule

// ----- hw/rtl/ising_metropolis_lattice.sv -----
// Load or flip: rows are fetched, the site evaluated and its row written back; a new item
// is taken only when the previous one is done: two read passes over the row memory
// (site and upper rows, then lower row), then the write-back before the next read.
// Recompute sweeps the rows, one memory row pair per cycle, then drains and reports totals.
// Reset clears totals, thresholds and control; the spin memory is not cleared.
`timescale 1ns / 1ps

module ising_metropolis_lattice
    import ilat_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OP_W-1:0]      op,
    input  logic [ROW_W-1:0]     row,
    input  logic [COL_W-1:0]     col,
    input  logic                 spin_up,
    input  logic [RAND_W-1:0]    rand_fraction,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 flipped,
    output logic signed [DE_W-1:0]     energy_change,
    output logic signed [ENERGY_W-1:0] energy_total,
    output logic signed [MAGNET_W-1:0] magnetization,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAND_W-1:0]    cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [OP_W-1:0] op_reg;
    row_idx_t        row_reg;
    col_idx_t        col_reg;
    logic            in_range_reg;
    logic            spin_up_reg;
    rand_t           rand_reg;
    row_bits_t       row_mid_reg;
    row_bits_t       row_up_reg;
    row_idx_t        sweep_row_reg;
    logic            tally_valid_reg;
    energy_t         e_acc_reg;
    magnet_t         m_acc_reg;
    energy_t         energy_reg;
    magnet_t         magnet_reg;
    rand_t           thr_four_reg;
    rand_t           thr_eight_reg;
    logic            out_valid_reg;
    logic            flipped_reg;
    de_t             de_reg;
    energy_t         energy_out_reg;
    magnet_t         magnet_out_reg;

    logic       in_take;
    logic       out_free;
    logic       in_range;
    row_idx_t   row_in_idx;
    row_idx_t   raddr_a;
    row_idx_t   raddr_b;
    row_bits_t  rdata_a;
    row_bits_t  rdata_b;
    row_bits_t  load_row;
    logic       mem_we;
    row_bits_t  mem_wdata;
    logic       flip_attempt;
    logic       flip_take;
    energy_t    de_ext;
    flip_eval_t eval;
    row_tally_t tally;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_take    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign cfg_ready  = 1'b1;
    assign row_in_idx = ROW_IDX_W'(row);
    assign in_range   = (LIM_W'(row) < LIM_W'(ROWS)) && (LIM_W'(col) < LIM_W'(COLS));

    // Pick the rows to read for the current step
    always_comb
    begin
        raddr_a = row_reg;
        raddr_b = row_prev(row_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                raddr_a = row_in_idx;
                raddr_b = row_prev(row_in_idx);
            end
            S_FETCH, S_EVAL:
            begin
                raddr_a = row_next(row_reg);
            end
            S_SWEEP:
            begin
                raddr_a = sweep_row_reg;
                raddr_b = row_next(sweep_row_reg);
            end
            default:
            begin
            end
        endcase
    end

    ilat_spin_ram #(
        .WIDTH (COLS),
        .DEPTH (ROWS)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (row_reg),
        .wdata   (mem_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    ilat_site_eval u_eval (
        .row_mid   (row_mid_reg),
        .row_up    (row_up_reg),
        .row_down  (rdata_a),
        .col_idx   (col_reg),
        .rand_val  (rand_reg),
        .thr_four  (thr_four_reg),
        .thr_eight (thr_eight_reg),
        .result    (eval)
    );

    ilat_row_tally u_tally (
        .row_cur   (rdata_a),
        .row_below (rdata_b),
        .tally     (tally)
    );

    // Build the write-back row and decide the commit
    always_comb
    begin
        load_row          = row_mid_reg;
        load_row[col_reg] = spin_up_reg;
        flip_attempt      = (op_reg == OP_FLIP) && in_range_reg;
        flip_take         = flip_attempt && eval.accept;
        mem_we            = (state_reg == S_EVAL) && out_free && in_range_reg
                          && ((op_reg == OP_LOAD) || flip_take);
        mem_wdata         = (op_reg == OP_LOAD) ? load_row : eval.new_row;
        de_ext            = {{(ENERGY_W - DE_W){eval.de[DE_W-1]}}, eval.de};
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (op == OP_RECOMP) ? S_SWEEP : S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                if (sweep_row_reg == ROW_IDX_W'(ROWS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Latch the item and capture rows
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg        <= op;
            row_reg       <= row_in_idx;
            col_reg       <= COL_IDX_W'(col);
            in_range_reg  <= in_range;
            spin_up_reg   <= spin_up;
            rand_reg      <= rand_fraction;
            sweep_row_reg <= '0;
        end
        else if (state_reg == S_SWEEP)
        begin
            sweep_row_reg <= row_next(sweep_row_reg);
        end
        if (state_reg == S_FETCH)
        begin
            row_mid_reg <= rdata_a;
            row_up_reg  <= rdata_b;
        end
    end

    // Accumulate row contributions during the sweep and drain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_valid_reg <= 1'b0;
            e_acc_reg       <= '0;
            m_acc_reg       <= '0;
        end
        else if (in_take)
        begin
            tally_valid_reg <= 1'b0;
            e_acc_reg       <= '0;
            m_acc_reg       <= '0;
        end
        else if ((state_reg == S_SWEEP) || (state_reg == S_DRAIN))
        begin
            tally_valid_reg <= (state_reg == S_SWEEP);
            if (tally_valid_reg)
            begin
                e_acc_reg <= e_acc_reg + tally.e_delta;
                m_acc_reg <= m_acc_reg + tally.m_delta;
            end
        end
    end

    // Hold the thresholds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_four_reg  <= '0;
            thr_eight_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_THR_FOUR:  thr_four_reg  <= cfg_data;
                CFG_THR_EIGHT: thr_eight_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Update totals on an accepted flip or a finished sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            magnet_reg <= '0;
        end
        else if ((state_reg == S_EVAL) && out_free && flip_take)
        begin
            energy_reg <= energy_reg + de_ext;
            magnet_reg <= eval.new_row[col_reg] ? magnet_reg + MAGNET_W'(2)
                                                : magnet_reg - MAGNET_W'(2);
        end
        else if ((state_reg == S_DONE) && out_free)
        begin
            energy_reg <= e_acc_reg;
            magnet_reg <= m_acc_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (((state_reg == S_EVAL) || (state_reg == S_DONE)) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_EVAL) && out_free)
        begin
            flipped_reg    <= flip_take;
            de_reg         <= flip_attempt ? eval.de : '0;
            energy_out_reg <= flip_take ? energy_reg + de_ext : energy_reg;
            magnet_out_reg <= flip_take ? (eval.new_row[col_reg] ? magnet_reg + MAGNET_W'(2)
                                                                 : magnet_reg - MAGNET_W'(2))
                                        : magnet_reg;
        end
        else if ((state_reg == S_DONE) && out_free)
        begin
            flipped_reg    <= 1'b0;
            de_reg         <= '0;
            energy_out_reg <= e_acc_reg;
            magnet_out_reg <= m_acc_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign flipped       = flipped_reg;
    assign energy_change = de_reg;
    assign energy_total  = energy_out_reg;
    assign magnetization = magnet_out_reg;

endmodule

// ----- hw/rtl/ilat_checker.sv -----
// Port-level checks for the Ising lattice block, bound to the top level.
// Depends on ilat_pkg and ising_metropolis_lattice.
`timescale 1ns / 1ps

module ilat_checker
    import ilat_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [OP_W-1:0]      op,
    input logic [ROW_W-1:0]     row,
    input logic [COL_W-1:0]     col,
    input logic                 spin_up,
    input logic [RAND_W-1:0]    rand_fraction,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 flipped,
    input logic signed [DE_W-1:0]     energy_change,
    input logic signed [ENERGY_W-1:0] energy_total,
    input logic signed [MAGNET_W-1:0] magnetization,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [RAND_W-1:0]    cfg_data
);

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // Stay busy in the cycle after taking an item
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new item taken while previous one in progress");

    // Report only energy changes of -8, -4, 0, 4 or 8
    a_de_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (energy_change == -5'sd8) || (energy_change == -5'sd4)
                   || (energy_change == 5'sd0) || (energy_change == 5'sd4)
                   || (energy_change == 5'sd8))
        else $error("illegal energy change reported");

    // Never reject a move that lowers the energy
    a_downhill_flips: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !flipped |-> (energy_change == 5'sd0) || (energy_change == 5'sd4)
                               || (energy_change == 5'sd8))
        else $error("downhill move rejected");

endmodule

bind ising_metropolis_lattice ilat_checker u_ilat_checker (.*);
